FILE: rtl/skeleton_frame_pose_builder_unit_assert.svh
// assertion macros used by the pose builder unit
`ifndef SKELETON_FRAME_POSE_BUILDER_UNIT_ASSERT_SVH
`define SKELETON_FRAME_POSE_BUILDER_UNIT_ASSERT_SVH

// implication checked every cycle outside reset
`define SFPB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the following cycle
`define SFPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sfpb_pkg.sv
package sfpb_pkg;

   typedef struct packed {
      logic               operation;
      logic [6:0]         joint_index;
      logic signed [7:0]  parent;
      logic [5:0]         flags;
      logic signed [31:0] value_0;
      logic signed [31:0] value_1;
      logic signed [31:0] value_2;
      logic signed [31:0] value_3;
      logic signed [31:0] value_4;
      logic signed [31:0] value_5;
   } req_word_type;

   typedef struct packed {
      logic [6:0]         posed_joint;
      logic signed [7:0]  posed_parent;
      logic signed [31:0] world_pos_x;
      logic signed [31:0] world_pos_y;
      logic signed [31:0] world_pos_z;
      logic signed [31:0] world_rot_x;
      logic signed [31:0] world_rot_y;
      logic signed [31:0] world_rot_z;
      logic signed [31:0] world_rot_w;
   } rsp_word_type;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ANIMATE = 1'b1;

   // isqrt unit handshake
   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [48:0] numer;
      logic [31:0] denom;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [48:0] quot;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD,
      ST_RD2,
      ST_MERGE,
      ST_WSQ,
      ST_WSQRT,
      ST_WSET,
      ST_PRD,
      ST_PRD2,
      ST_QM,
      ST_QMSUM,
      ST_NSQ,
      ST_NSQRT,
      ST_NDIV,
      ST_NDIVW,
      ST_WRITE,
      ST_OUT
   } state_type;

   // quaternion multiply passes
   localparam logic [1:0] PASS_T   = 2'd0;
   localparam logic [1:0] PASS_R   = 2'd1;
   localparam logic [1:0] PASS_ROT = 2'd2;

   // sum of four rounded products needs 50 bits before clamping
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7fffffff;
      if (v < -50'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

FILE: rtl/sfpb_sqrt.sv
module sfpb_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  sfpb_pkg::sqrt_req_type sq_req,
   output sfpb_pkg::sqrt_rsp_type sq_rsp
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   // one result bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = res_ff + bit_ff;
      if (sq_req.start) begin
         rem_in  = sq_req.radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sq_rsp.busy = busy_ff;
   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = res_ff[31:0];

endmodule

FILE: rtl/sfpb_div.sv
module sfpb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sfpb_pkg::div_req_type dv_req,
   output sfpb_pkg::div_rsp_type dv_rsp
);

   logic [48:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[48]};
      if (dv_req.start) begin
         quo_in  = dv_req.numer;
         rem_in  = '0;
         den_in  = dv_req.denom;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign dv_rsp.busy = busy_ff;
   assign dv_rsp.done = done_ff;
   assign dv_rsp.quot = quo_ff;

endmodule

FILE: rtl/skeleton_frame_pose_builder_unit.sv
// Quaternion forward kinematics for one skeleton frame, Q16.16 throughout.
// A load word stores a joint's base pose and gives no result; an animate
// word merges the flagged channels, rebuilds quaternion w and, for a child,
// rotates and offsets by the posed parent, returning one posed word.
// For a child animate, the shared 32x32 multiplier runs 56 products one per
// cycle, a bit-serial square root is used for w and again for the norm, and
// four serial divides normalize the rotation unless its norm is zero. A posed
// word still stalled on the result side holds the next animate word in its
// output state. The block takes no word while one is in work. Parents must be
// posed before children.
`include "skeleton_frame_pose_builder_unit_assert.svh"

module skeleton_frame_pose_builder_unit #(
   parameter int MAX_JOINTS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sfpb_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sfpb_pkg::rsp_word_type rsp_word
);

   localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   // joint memories, one row per joint
   logic signed [7:0]  mem_par [MAX_JOINTS];
   logic [5:0]         mem_flg [MAX_JOINTS];
   logic [95:0]        mem_bpos [MAX_JOINTS];
   logic [95:0]        mem_brot [MAX_JOINTS];
   logic [95:0]        mem_ppos [MAX_JOINTS];
   logic [127:0]       mem_prot [MAX_JOINTS];

   sfpb_pkg::state_type state_ff, state_in;
   sfpb_pkg::req_word_type item_ff;
   sfpb_pkg::rsp_word_type out_ff;

   logic signed [7:0]  par_rd_ff;
   logic [5:0]         flg_rd_ff;
   logic [95:0]        bpos_rd_ff, brot_rd_ff, ppos_rd_ff;
   logic [127:0]       prot_rd_ff;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] rot_ff [4];
   logic signed [31:0] pq_ff [4];
   logic signed [31:0] qa_ff [4];
   logic signed [31:0] qb_ff [4];
   logic signed [31:0] qr_ff [4];
   logic signed [31:0] wp_ff [3];
   logic [4:0]         step_ff;
   logic [1:0]         pass_ff;
   logic [1:0]         comp_ff;
   logic [1:0]         sq_sel_ff;
   logic [65:0]        ssum_ff;
   logic [31:0]        mag_ff;
   logic signed [49:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic               prod_vld_ff;
   logic               prod_neg_ff;
   logic               prod_last_ff;
   logic               is_root_ff;
   logic               div_neg_ff;

   logic               out_vld_ff;
   logic               do_start;
   logic               acc_ok;

   // memory addresses of the joint in work and of its parent
   logic [AW-1:0]      jidx;
   logic [AW-1:0]      pidx;

   sfpb_pkg::sqrt_req_type sq_req;
   sfpb_pkg::sqrt_rsp_type sq_rsp;
   sfpb_pkg::div_req_type  dv_req;
   sfpb_pkg::div_rsp_type  dv_rsp;

   sfpb_sqrt u_sqrt (.clock(clock), .reset(reset), .sq_req(sq_req), .sq_rsp(sq_rsp));
   sfpb_div  u_div  (.clock(clock), .reset(reset), .dv_req(dv_req), .dv_rsp(dv_rsp));

   assign req_stall = (state_ff != sfpb_pkg::ST_IDLE);
   assign acc_ok    = req_valid && !req_stall;
   assign do_start  = acc_ok && ({25'd0, req_word.joint_index} < 32'(MAX_JOINTS));
   assign jidx      = AW'(item_ff.joint_index);
   assign pidx      = AW'(par_rd_ff);

   // shared multiplier operand selection (quaternion products, squares)
   logic signed [31:0] mul_a, mul_b;
   logic               mul_neg;
   logic               mul_go;
   logic [1:0]         ia, ib;

   // Hamilton product term table: per output comp 4 terms (a idx, b idx, sign)
   always_comb begin
      ia = 2'd0;
      ib = 2'd0;
      mul_neg = 1'b0;
      unique case ({comp_ff, step_ff[1:0]})
         4'h0: begin ia = 2'd0; ib = 2'd3; end
         4'h1: begin ia = 2'd3; ib = 2'd0; end
         4'h2: begin ia = 2'd1; ib = 2'd2; end
         4'h3: begin ia = 2'd2; ib = 2'd1; mul_neg = 1'b1; end
         4'h4: begin ia = 2'd1; ib = 2'd3; end
         4'h5: begin ia = 2'd3; ib = 2'd1; end
         4'h6: begin ia = 2'd2; ib = 2'd0; end
         4'h7: begin ia = 2'd0; ib = 2'd2; mul_neg = 1'b1; end
         4'h8: begin ia = 2'd2; ib = 2'd3; end
         4'h9: begin ia = 2'd3; ib = 2'd2; end
         4'ha: begin ia = 2'd0; ib = 2'd1; end
         4'hb: begin ia = 2'd1; ib = 2'd0; mul_neg = 1'b1; end
         4'hc: begin ia = 2'd3; ib = 2'd3; end
         4'hd: begin ia = 2'd0; ib = 2'd0; mul_neg = 1'b1; end
         4'he: begin ia = 2'd1; ib = 2'd1; mul_neg = 1'b1; end
         4'hf: begin ia = 2'd2; ib = 2'd2; mul_neg = 1'b1; end
         default: begin ia = 2'd0; ib = 2'd0; end
      endcase
   end

   always_comb begin
      mul_go = 1'b0;
      mul_a  = qa_ff[ia];
      mul_b  = qb_ff[ib];
      unique case (state_ff)
         sfpb_pkg::ST_QM: mul_go = 1'b1;
         sfpb_pkg::ST_WSQ, sfpb_pkg::ST_NSQ: begin
            mul_go = 1'b1;
            mul_a  = qa_ff[sq_sel_ff];
            mul_b  = qa_ff[sq_sel_ff];
         end
         default: mul_go = 1'b0;
      endcase
   end

   // rounded product of the multiplier register
   logic signed [47:0] prod_rnd;
   assign prod_rnd = 48'((prod_ff + 64'sd32768) >>> 16);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfpb_pkg::ST_IDLE: if (do_start) begin
            state_in = (req_word.operation == sfpb_pkg::OP_LOAD) ?
                       sfpb_pkg::ST_WRITE : sfpb_pkg::ST_RD;
         end
         sfpb_pkg::ST_RD:    state_in = sfpb_pkg::ST_RD2;
         sfpb_pkg::ST_RD2:   state_in = sfpb_pkg::ST_MERGE;
         sfpb_pkg::ST_MERGE: state_in = sfpb_pkg::ST_WSQ;
         sfpb_pkg::ST_WSQ:   if (sq_sel_ff == 2'd3) state_in = sfpb_pkg::ST_WSQRT;
         sfpb_pkg::ST_WSQRT: if (sq_rsp.done) state_in = sfpb_pkg::ST_WSET;
         sfpb_pkg::ST_WSET:
            state_in = is_root_ff ? sfpb_pkg::ST_WRITE : sfpb_pkg::ST_PRD;
         sfpb_pkg::ST_PRD:   state_in = sfpb_pkg::ST_PRD2;
         sfpb_pkg::ST_PRD2:  state_in = sfpb_pkg::ST_QM;
         sfpb_pkg::ST_QM:    if (step_ff == 5'd15) state_in = sfpb_pkg::ST_QMSUM;
         sfpb_pkg::ST_QMSUM: if (prod_last_ff) begin
            unique case (pass_ff)
               sfpb_pkg::PASS_ROT: state_in = sfpb_pkg::ST_NSQ;
               default:            state_in = sfpb_pkg::ST_QM;
            endcase
         end
         sfpb_pkg::ST_NSQ:   if (sq_sel_ff == 2'd3) state_in = sfpb_pkg::ST_NSQRT;
         sfpb_pkg::ST_NSQRT: if (sq_rsp.done) state_in = sfpb_pkg::ST_NDIV;
         sfpb_pkg::ST_NDIV:
            state_in = (mag_ff == 32'd0) ? sfpb_pkg::ST_WRITE : sfpb_pkg::ST_NDIVW;
         sfpb_pkg::ST_NDIVW: if (dv_rsp.done) begin
            state_in = (comp_ff == 2'd3) ? sfpb_pkg::ST_WRITE : sfpb_pkg::ST_NDIV;
         end
         sfpb_pkg::ST_WRITE:
            state_in = (item_ff.operation == sfpb_pkg::OP_LOAD) ?
                       sfpb_pkg::ST_IDLE : sfpb_pkg::ST_OUT;
         sfpb_pkg::ST_OUT:   if (!out_vld_ff || !rsp_stall) state_in = sfpb_pkg::ST_IDLE;
         default:            state_in = sfpb_pkg::ST_IDLE;
      endcase
   end

   // unit requests
   logic [65:0] wrad;
   always_comb begin
      sq_req = '0;
      dv_req = '0;
      wrad   = 66'h1_0000_0000 - ssum_ff;
      if (state_ff == sfpb_pkg::ST_WSQRT && !sq_rsp.busy && !sq_rsp.done &&
          !prod_vld_ff) begin
         sq_req.start    = 1'b1;
         sq_req.radicand = (ssum_ff >= 66'h1_0000_0000) ? 64'd0 : wrad[63:0];
      end
      if (state_ff == sfpb_pkg::ST_NSQRT && !sq_rsp.busy && !sq_rsp.done &&
          !prod_vld_ff) begin
         sq_req.start    = 1'b1;
         sq_req.radicand = (ssum_ff[65:64] != 2'd0) ? 64'hffff_ffff_ffff_ffff :
                           ssum_ff[63:0];
      end
      if (state_ff == sfpb_pkg::ST_NDIV && mag_ff != 32'd0) begin
         dv_req.start = 1'b1;
         dv_req.numer = {1'b0, (qr_ff[comp_ff][31] ? 32'(-qr_ff[comp_ff]) :
                                32'(qr_ff[comp_ff])), 16'd0} + 49'(mag_ff >> 1);
         dv_req.denom = mag_ff;
      end
   end

   // abs square of a 32-bit value fits 64 bits unsigned
   logic [63:0] sq_abs;
   assign sq_abs = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);

   logic signed [31:0] div_val;
   logic [48:0]        dq;
   always_comb begin
      dq = (dv_rsp.quot > 49'h1_0000_0000) ? 49'h1_0000_0000 : dv_rsp.quot;
      if (div_neg_ff) div_val = sfpb_pkg::sat32(-50'(dq));
      else            div_val = sfpb_pkg::sat32(50'(dq));
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sfpb_pkg::ST_IDLE;
         out_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= mul_go;
         if (state_ff == sfpb_pkg::ST_OUT && (!out_vld_ff || !rsp_stall))
            out_vld_ff <= 1'b1;
         else if (out_vld_ff && !rsp_stall)
            out_vld_ff <= 1'b0;
      end

      prod_ff      <= 64'(mul_a) * 64'(mul_b);
      prod_neg_ff  <= mul_neg;
      prod_last_ff <= mul_go && (state_ff == sfpb_pkg::ST_QM) && (step_ff == 5'd15);

      if (acc_ok) begin
         item_ff <= req_word;
      end

      unique case (state_ff)
         sfpb_pkg::ST_RD: begin
            par_rd_ff  <= mem_par[jidx];
            flg_rd_ff  <= mem_flg[jidx];
            bpos_rd_ff <= mem_bpos[jidx];
            brot_rd_ff <= mem_brot[jidx];
         end
         sfpb_pkg::ST_RD2: begin
            is_root_ff <= par_rd_ff[7] ||
                          ({24'd0, par_rd_ff} >= 32'(MAX_JOINTS));
         end
         sfpb_pkg::ST_MERGE: begin : merge
            logic signed [31:0] vals [6];
            logic signed [31:0] base [6];
            logic [2:0]         used;
            vals[0] = item_ff.value_0; vals[1] = item_ff.value_1;
            vals[2] = item_ff.value_2; vals[3] = item_ff.value_3;
            vals[4] = item_ff.value_4; vals[5] = item_ff.value_5;
            base[0] = bpos_rd_ff[31:0];  base[1] = bpos_rd_ff[63:32];
            base[2] = bpos_rd_ff[95:64]; base[3] = brot_rd_ff[31:0];
            base[4] = brot_rd_ff[63:32]; base[5] = brot_rd_ff[95:64];
            used = 3'd0;
            for (int k = 0; k < 6; k++) begin
               if (flg_rd_ff[k]) begin
                  base[k] = vals[used];
                  used = used + 3'd1;
               end
            end
            for (int k = 0; k < 3; k++) pos_ff[k] <= base[k];
            for (int k = 0; k < 3; k++) begin
               rot_ff[k] <= base[3+k];
               qa_ff[k]  <= base[3+k];
            end
            qa_ff[3]  <= 32'sd0;
            sq_sel_ff <= 2'd0;
            ssum_ff   <= '0;
         end
         sfpb_pkg::ST_WSQ, sfpb_pkg::ST_NSQ: begin
            sq_sel_ff <= sq_sel_ff + 2'd1;
         end
         sfpb_pkg::ST_WSET: begin
            rot_ff[3] <= (ssum_ff >= 66'h1_0000_0000) ? 32'sd0 : -$signed(sq_rsp.root);
         end
         sfpb_pkg::ST_PRD: begin
            ppos_rd_ff <= mem_ppos[pidx];
            prot_rd_ff <= mem_prot[pidx];
         end
         sfpb_pkg::ST_PRD2: begin
            for (int k = 0; k < 4; k++) begin
               pq_ff[k] <= prot_rd_ff[32*k +: 32];
               qa_ff[k] <= prot_rd_ff[32*k +: 32];
            end
            for (int k = 0; k < 3; k++) qb_ff[k] <= pos_ff[k];
            qb_ff[3] <= 32'sd0;
            pass_ff  <= sfpb_pkg::PASS_T;
            step_ff  <= 5'd0;
            comp_ff  <= 2'd0;
            acc_ff   <= '0;
         end
         sfpb_pkg::ST_QM: begin
            step_ff <= step_ff + 5'd1;
            comp_ff <= 2'((step_ff + 5'd1) >> 2);
         end
         default: ;
      endcase

      // accumulate squares
      if (prod_vld_ff && (state_ff == sfpb_pkg::ST_WSQ || state_ff == sfpb_pkg::ST_WSQRT ||
                          state_ff == sfpb_pkg::ST_NSQ || state_ff == sfpb_pkg::ST_NSQRT))
         ssum_ff <= ssum_ff + {2'b00, sq_abs};

      // accumulate quaternion terms, one output comp per four products
      if (prod_vld_ff && (state_ff == sfpb_pkg::ST_QM || state_ff == sfpb_pkg::ST_QMSUM)) begin : qacc
         logic signed [49:0] nxt;
         logic [1:0]         ci;
         nxt = prod_neg_ff ? acc_ff - 50'(prod_rnd) : acc_ff + 50'(prod_rnd);
         ci  = (state_ff == sfpb_pkg::ST_QMSUM) ? 2'd3 : 2'((step_ff - 5'd1) >> 2);
         if (((state_ff == sfpb_pkg::ST_QM) && (step_ff[1:0] == 2'd0)) ||
             (state_ff == sfpb_pkg::ST_QMSUM)) begin
            qr_ff[ci] <= sfpb_pkg::sat32(nxt);
            acc_ff    <= '0;
         end else begin
            acc_ff <= nxt;
         end
      end

      // advance passes at the end of each product
      if (state_ff == sfpb_pkg::ST_QMSUM && prod_last_ff) begin : pass_adv
         logic signed [31:0] r3;
         r3 = sfpb_pkg::sat32(prod_neg_ff ? acc_ff - 50'(prod_rnd) : acc_ff + 50'(prod_rnd));
         step_ff <= 5'd0;
         comp_ff <= 2'd0;
         unique case (pass_ff)
            sfpb_pkg::PASS_T: begin
               qa_ff[0] <= qr_ff[0]; qa_ff[1] <= qr_ff[1];
               qa_ff[2] <= qr_ff[2]; qa_ff[3] <= r3;
               for (int k = 0; k < 3; k++)
                  qb_ff[k] <= sfpb_pkg::sat32(-50'(pq_ff[k]));
               qb_ff[3] <= pq_ff[3];
               pass_ff  <= sfpb_pkg::PASS_R;
            end
            sfpb_pkg::PASS_R: begin
               for (int k = 0; k < 3; k++)
                  wp_ff[k] <= sfpb_pkg::sat32(50'(qr_ff[k]) +
                                              50'($signed(ppos_rd_ff[32*k +: 32])));
               for (int k = 0; k < 4; k++) begin
                  qa_ff[k] <= pq_ff[k];
                  qb_ff[k] <= rot_ff[k];
               end
               pass_ff <= sfpb_pkg::PASS_ROT;
            end
            default: begin
               // qr w is stored by the accumulator in this same cycle
               for (int k = 0; k < 3; k++) qa_ff[k] <= qr_ff[k];
               qa_ff[3]  <= r3;
               sq_sel_ff <= 2'd0;
               ssum_ff   <= '0;
            end
         endcase
      end

      if (state_ff == sfpb_pkg::ST_NSQRT && sq_rsp.done) begin
         mag_ff  <= sq_rsp.root;
         comp_ff <= 2'd0;
      end
      if (state_ff == sfpb_pkg::ST_NDIV) begin
         div_neg_ff <= qr_ff[comp_ff][31];
      end
      if (state_ff == sfpb_pkg::ST_NDIVW && dv_rsp.done) begin
         qr_ff[comp_ff] <= div_val;
         comp_ff        <= comp_ff + 2'd1;
      end

      // memory writes
      if (state_ff == sfpb_pkg::ST_WRITE) begin
         if (item_ff.operation == sfpb_pkg::OP_LOAD) begin
            mem_par[jidx]  <= item_ff.parent;
            mem_flg[jidx]  <= item_ff.flags;
            mem_bpos[jidx] <= {item_ff.value_2, item_ff.value_1, item_ff.value_0};
            mem_brot[jidx] <= {item_ff.value_5, item_ff.value_4, item_ff.value_3};
         end else if (is_root_ff) begin
            mem_ppos[jidx] <= {pos_ff[2], pos_ff[1], pos_ff[0]};
            mem_prot[jidx] <= {rot_ff[3], rot_ff[2], rot_ff[1], rot_ff[0]};
         end else begin
            mem_ppos[jidx] <= {wp_ff[2], wp_ff[1], wp_ff[0]};
            mem_prot[jidx] <= {qr_ff[3], qr_ff[2], qr_ff[1], qr_ff[0]};
         end
      end

      // result word, loaded only once the previous one has left
      if (state_ff == sfpb_pkg::ST_OUT && (!out_vld_ff || !rsp_stall)) begin
         if (is_root_ff) begin
            out_ff <= {item_ff.joint_index, par_rd_ff, pos_ff[0], pos_ff[1], pos_ff[2],
                       rot_ff[0], rot_ff[1], rot_ff[2], rot_ff[3]};
         end else begin
            out_ff <= {item_ff.joint_index, par_rd_ff, wp_ff[0], wp_ff[1], wp_ff[2],
                       qr_ff[0], qr_ff[1], qr_ff[2], qr_ff[3]};
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   `SFPB_ASSERT_IMP(a_busy_stall, clock, reset,
      state_ff != sfpb_pkg::ST_IDLE, req_stall, "input taken while busy")
   `SFPB_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result dropped")
   `SFPB_ASSERT_IMP(a_one_unit, clock, reset,
      1'b1, !(sq_rsp.busy && dv_rsp.busy), "sqrt and divide overlap")

endmodule
